// ===== rtl/core/spng_pkg.sv =====
// Shared types, constants and checksum functions for the screen-to-PNG stream encoder.
package spng_pkg;

    localparam int SCREEN_COLS   = 128;
    localparam int SCREEN_ROWS   = 32;
    localparam int PAIRS_PER_ROW = SCREEN_COLS / 4;
    localparam int FRAME_PAIRS   = PAIRS_PER_ROW * SCREEN_ROWS;
    localparam int POS_W         = $clog2(FRAME_PAIRS);
    localparam int ROW_W         = $clog2(PAIRS_PER_ROW);
    localparam int HEAD_BYTES    = 48;
    localparam int CRC_FROM      = 37;
    localparam int TAIL_BYTES    = 20;
    localparam int IDX_W         = 6;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [IDX_W-1:0] HEAD_LAST    = IDX_W'(HEAD_BYTES - 1);
    localparam logic [IDX_W-1:0] TAIL_LAST    = IDX_W'(TAIL_BYTES - 1);
    localparam logic [IDX_W-1:0] CRC_FROM_IDX = IDX_W'(CRC_FROM);
    localparam logic [IDX_W-1:0] TAIL_CRC_IDX = IDX_W'(4);
    localparam logic [IDX_W-1:0] TAIL_FIX_IDX = IDX_W'(8);

    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [31:0] CRC_POLY  = 32'hedb88320;
    localparam logic [31:0] CRC_INIT  = 32'hffffffff;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
    } t_pair;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_last;
    } t_png_word;

    // One classified pair as it waits between the front and the back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       row_start;
        logic       last;
    } t_entry;

    typedef enum logic [2:0] {
        PH_START,
        PH_HEAD,
        PH_FILT,
        PH_DATA,
        PH_TAIL
    } t_phase;

    function automatic logic [7:0] head_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:  b = 8'h89;
            6'd1:  b = 8'h50;
            6'd2:  b = 8'h4e;
            6'd3:  b = 8'h47;
            6'd4:  b = 8'h0d;
            6'd5:  b = 8'h0a;
            6'd6:  b = 8'h1a;
            6'd7:  b = 8'h0a;
            6'd11: b = 8'h0d;
            6'd12: b = 8'h49;
            6'd13: b = 8'h48;
            6'd14: b = 8'h44;
            6'd15: b = 8'h52;
            6'd19: b = 8'(SCREEN_COLS);
            6'd23: b = 8'(SCREEN_ROWS);
            6'd24: b = 8'h02;
            6'd29: b = 8'hb5;
            6'd30: b = 8'hf9;
            6'd31: b = 8'h37;
            6'd32: b = 8'h58;
            6'd35: b = 8'h04;
            6'd36: b = 8'h2b;
            6'd37: b = 8'h49;
            6'd38: b = 8'h44;
            6'd39: b = 8'h41;
            6'd40: b = 8'h54;
            6'd41: b = 8'h48;
            6'd42: b = 8'h0d;
            6'd43: b = 8'h01;
            6'd44: b = 8'h20;
            6'd45: b = 8'h04;
            6'd46: b = 8'hdf;
            6'd47: b = 8'hfb;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // IEND chunk, which follows the Adler and CRC words in the trailer.
    function automatic logic [7:0] tail_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            6'd12: b = 8'h49;
            6'd13: b = 8'h45;
            6'd14: b = 8'h4e;
            6'd15: b = 8'h44;
            6'd16: b = 8'hae;
            6'd17: b = 8'h42;
            6'd18: b = 8'h60;
            6'd19: b = 8'h82;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ ((c[0] ^ b[i]) ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    // Both operands are below the modulus, so one subtraction suffices.
    function automatic logic [15:0] adler_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= ADLER_MOD) begin
            s = s - ADLER_MOD;
        end
        return s[15:0];
    endfunction

endpackage

// ===== rtl/core/spng_front.sv =====
// Front end: accepts pixel pairs, packs them and marks frame and row boundaries.
module spng_front import spng_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_pair  i_pair,
    output logic   o_stall,
    input  logic   i_full,
    output logic   o_push,
    output t_entry o_entry
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             w_last;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;
    assign w_last  = (r_pos == POS_W'(FRAME_PAIRS - 1));

    always_comb begin
        o_entry.data_byte = {i_pair.first_byte[1:0], i_pair.first_byte[5:4],
                             i_pair.second_byte[1:0], i_pair.second_byte[5:4]};
        o_entry.first     = (r_pos == '0);
        o_entry.row_start = (r_pos[ROW_W-1:0] == '0);
        o_entry.last      = w_last;
    end

    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            n_pos = w_last ? '0 : r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ===== rtl/core/spng_queue.sv =====
// Short first-in first-out queue of classified pairs between front and back.
module spng_queue import spng_pkg::*; #(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_head
);

    localparam int PW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(P_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(P_DEPTH);

    t_entry          r_slot [P_DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_slot[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/spng_back.sv =====
// Back end: byte sequencer with running Adler-32 and CRC-32 and the output register.
module spng_back import spng_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_entry    i_head,
    output logic      o_pop,
    output logic      o_valid,
    output t_png_word o_word,
    input  logic      i_stall
);

    t_phase           r_phase;
    t_phase           n_phase;
    t_phase           w_phase;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_out_valid;
    t_png_word        r_out;
    logic [15:0]      r_al;
    logic [15:0]      r_ah;
    logic [31:0]      r_crc;
    logic [15:0]      n_al;
    logic [31:0]      w_crc_x;
    logic             w_free;
    logic             w_step;
    logic [7:0]       w_byte;
    logic             w_crc_on;
    logic             w_adler_on;
    logic             w_init;
    logic             w_run_last;
    logic             w_frame_last;

    assign w_free  = !r_out_valid || !i_stall;
    assign w_step  = i_head_valid && w_free;
    assign w_crc_x = ~r_crc;
    assign n_al    = adler_add(r_al, {8'd0, w_byte});
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    // At the start of an entry the phase follows from the entry's marks.
    always_comb begin
        if (r_phase == PH_START) begin
            if (i_head.first) begin
                w_phase = PH_HEAD;
            end else if (i_head.row_start) begin
                w_phase = PH_FILT;
            end else begin
                w_phase = PH_DATA;
            end
        end else begin
            w_phase = r_phase;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        if (w_step) begin
            case (w_phase)
                PH_HEAD: begin
                    if (r_idx == HEAD_LAST) begin
                        n_idx   = '0;
                        n_phase = i_head.row_start ? PH_FILT : PH_DATA;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_phase = PH_HEAD;
                    end
                end
                PH_FILT: begin
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    n_idx   = '0;
                    n_phase = i_head.last ? PH_TAIL : PH_START;
                end
                PH_TAIL: begin
                    if (r_idx == TAIL_LAST) begin
                        n_idx   = '0;
                        n_phase = PH_START;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_phase = PH_TAIL;
                    end
                end
                default: begin
                    n_idx   = '0;
                    n_phase = PH_START;
                end
            endcase
        end
    end

    always_comb begin
        w_byte       = 8'h00;
        w_crc_on     = 1'b0;
        w_adler_on   = 1'b0;
        w_init       = 1'b0;
        w_run_last   = 1'b0;
        w_frame_last = 1'b0;
        case (w_phase)
            PH_HEAD: begin
                w_byte   = head_byte(r_idx);
                w_crc_on = (r_idx >= CRC_FROM_IDX);
                w_init   = (r_idx == '0);
            end
            PH_FILT: begin
                w_crc_on   = 1'b1;
                w_adler_on = 1'b1;
            end
            PH_DATA: begin
                w_byte     = i_head.data_byte;
                w_crc_on   = 1'b1;
                w_adler_on = 1'b1;
                w_run_last = !i_head.last;
            end
            PH_TAIL: begin
                if (r_idx < TAIL_CRC_IDX) begin
                    w_crc_on = 1'b1;
                    case (r_idx[1:0])
                        2'd0:    w_byte = r_ah[15:8];
                        2'd1:    w_byte = r_ah[7:0];
                        2'd2:    w_byte = r_al[15:8];
                        default: w_byte = r_al[7:0];
                    endcase
                end else if (r_idx < TAIL_FIX_IDX) begin
                    case (r_idx[1:0])
                        2'd0:    w_byte = w_crc_x[31:24];
                        2'd1:    w_byte = w_crc_x[23:16];
                        2'd2:    w_byte = w_crc_x[15:8];
                        default: w_byte = w_crc_x[7:0];
                    endcase
                end else begin
                    w_byte = tail_byte(r_idx);
                end
                w_run_last   = (r_idx == TAIL_LAST);
                w_frame_last = (r_idx == TAIL_LAST);
            end
            default: begin
                w_byte = 8'h00;
            end
        endcase
        o_pop = w_step && w_run_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out.out_byte   <= w_byte;
            r_out.run_last   <= w_run_last;
            r_out.frame_last <= w_frame_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_al        <= 16'd1;
            r_ah        <= 16'd0;
            r_crc       <= CRC_INIT;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            if (w_free) begin
                r_out_valid <= w_step;
            end
            if (w_step) begin
                if (w_init) begin
                    r_al  <= 16'd1;
                    r_ah  <= 16'd0;
                    r_crc <= CRC_INIT;
                end else begin
                    if (w_crc_on) begin
                        r_crc <= crc_byte(r_crc, w_byte);
                    end
                    if (w_adler_on) begin
                        r_al <= n_al;
                        r_ah <= adler_add(r_ah, n_al);
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/core/screen_to_png_stream_encoder.sv =====
// Top level of the screen-to-PNG stream encoder: front end, queue and byte sequencer.
// With the back end idle, an accepted pair is written into a queue slot and its first output
// word is then loaded into the output register. Throughput: one output word per cycle while
// the queue holds an entry and i_stall is low, set by the byte sequencer in the back end; a
// pair costs 1 word, 2 at a row start, plus 48 header words and 20 trailer words per frame.
// Reset is synchronous and active low; it returns the frame position and checksums to start.
module screen_to_png_stream_encoder import spng_pkg::*; #(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_pair     i_pair,
    output logic      o_stall,
    output logic      o_valid,
    output t_png_word o_word,
    input  logic      i_stall
);

    // The front end counts pairs through the frame and tags each packed
    // byte with whether it opens the frame, opens a row or closes the frame.
    logic   w_push;
    logic   w_full;
    t_entry w_entry;

    // The queue lets the front keep taking pairs while the back is busy
    // sending a header, a filter byte or the trailer.
    logic   w_pop;
    logic   w_head_valid;
    t_entry w_head;

    spng_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_pair  (i_pair),
        .o_stall (o_stall),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    spng_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_head  (w_head)
    );

    // The back end walks each entry through its words, keeps the running
    // checksums and holds the result in an output register, which frees the
    // sequencer for the next word as soon as the current one is taken.
    spng_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .o_word       (o_word),
        .i_stall      (i_stall)
    );

endmodule

// ===== rtl/core/spng_checker.sv =====
// Port-level checks for the screen-to-PNG stream encoder and their binding.
module spng_checker import spng_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input t_pair     i_pair,
    input logic      o_stall,
    input logic      o_valid,
    input t_png_word o_word,
    input logic      i_stall
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_pair))
        else $error("stalled input word changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word))
        else $error("stalled output word changed");

    a_frame_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.frame_last |-> o_word.run_last)
        else $error("end of file without end of run");

    a_iend_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.frame_last |-> o_word.out_byte == 8'h82)
        else $error("last word of file is not the end of the IEND CRC");

    a_next_sig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_word.frame_last |=> !o_valid || o_word.out_byte == 8'h89)
        else $error("new file does not start with the PNG signature");

endmodule

bind screen_to_png_stream_encoder spng_checker u_spng_checker (.*);
